// File: rtl/core/cht_pkg.sv
// Package: command, status and state machine types for the hash table engine.
`default_nettype none
package cht_pkg;
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_POOL_FULL = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HEAD,
      S_NODE,
      S_DECIDE,
      S_FREE,
      S_RESP
   } state_type;

   localparam logic [3:0] INDEX_BITS_RESET = 4'd10;
endpackage
`default_nettype wire

// File: rtl/core/chained_hash_table_engine.sv
// Top level: hash table with separate chaining held in block memories.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | req_cmd, req_key, req_value
//   rsp     | out | rsp_valid/rsp_ready | rsp_status, rsp_value
//   csr     | in  | csr_valid/csr_ready | csr_data (index_bits)
//
// One command at a time. Per command: accept with the head read issued, head
// compare, one step per chain node visited, a decision, then the response is
// loaded, with a free-list step between decision and response when a node
// joins or leaves the free list. The response is registered from S_RESP.
// The loop is the node memory read: one chain hop per cycle.
// After reset a clearing pass initializes the link memories; commands wait,
// config writes are taken. A held response blocks the next word; the word can
// be taken in the cycle the response leaves.
`default_nettype none
module chained_hash_table_engine
   import cht_pkg::*;
#(
   parameter int BUCKET_BITS = 10,
   parameter int POOL_NODES  = 1024,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire [1:0]              req_cmd,
   input  wire [KEY_WIDTH-1:0]    req_key,
   input  wire [VALUE_WIDTH-1:0]  req_value,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [3:0]              csr_data
);
   localparam int NB = 1 << BUCKET_BITS;
   localparam int LW = $clog2(POOL_NODES + 1);        // link width, null = POOL_NODES
   localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int CLR = (NB > POOL_NODES) ? NB : POOL_NODES;
   localparam int CW = $clog2(CLR + 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

   // memories
   logic                  bv_mem [NB];
   logic [KEY_WIDTH-1:0]  bk_mem [NB];
   logic [VALUE_WIDTH-1:0] bval_mem [NB];
   logic [LW-1:0]         bn_mem [NB];
   logic [KEY_WIDTH-1:0]  nk_mem [POOL_NODES];
   logic [VALUE_WIDTH-1:0] nval_mem [POOL_NODES];
   logic [LW-1:0]         nn_mem [POOL_NODES];

   state_type state_ff, state_in;
   logic [3:0]  ibits_ff;
   logic [CW-1:0] clr_ff, clr_in;
   cmd_type     cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [BUCKET_BITS-1:0] bkt_ff, bkt_in;
   logic [LW-1:0] free_ff, free_in;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [CW-1:0] hop_ff, hop_in;
   logic          athead_ff, athead_in, found_ff, found_in, hvalid_ff, hvalid_in;
   logic [LW-1:0] curnext_ff, curnext_in;
   logic          rv_ff, rv_in;
   logic [1:0]    st_ff, st_in;
   logic [VALUE_WIDTH-1:0] vo_ff, vo_in;

   // registered read data
   logic                   bv_q;
   logic [KEY_WIDTH-1:0]   bk_q;
   logic [VALUE_WIDTH-1:0] bval_q;
   logic [LW-1:0]          bn_q;
   logic [KEY_WIDTH-1:0]   nk_q;
   logic [VALUE_WIDTH-1:0] nval_q;
   logic [LW-1:0]          nn_q;

   // port controls
   logic [BUCKET_BITS-1:0] b_raddr, b_waddr;
   logic [PW-1:0] n_raddr, n_waddr;
   logic bv_we, bkv_we, bn_we, nkv_we, nn_we, bv_wd;
   logic [LW-1:0] bn_wd, nn_wd;
   logic [VALUE_WIDTH-1:0] bval_wd;

   always_ff @(posedge clock) begin
      bv_q   <= bv_mem[b_raddr];
      bk_q   <= bk_mem[b_raddr];
      bval_q <= bval_mem[b_raddr];
      bn_q   <= bn_mem[b_raddr];
      nk_q   <= nk_mem[n_raddr];
      nval_q <= nval_mem[n_raddr];
      nn_q   <= nn_mem[n_raddr];
      if (bv_we) bv_mem[b_waddr] <= bv_wd;
      if (bkv_we) begin
         bk_mem[b_waddr]   <= key_ff;
         bval_mem[b_waddr] <= bval_wd;
      end
      if (bn_we) bn_mem[b_waddr] <= bn_wd;
      if (nkv_we) begin
         nk_mem[n_waddr]   <= key_ff;
         nval_mem[n_waddr] <= val_ff;
      end
      if (nn_we) nn_mem[n_waddr] <= nn_wd;
   end

   // bucket select with saturated index width
   logic [3:0] bits_sat;
   logic [KEY_WIDTH-1:0] bmask;
   assign bits_sat = (ibits_ff > 4'(BUCKET_BITS > 15 ? 15 : BUCKET_BITS)
                      && BUCKET_BITS < 15) ? 4'(BUCKET_BITS) : ibits_ff;
   always_comb bmask = ~({KEY_WIDTH{1'b1}} << bits_sat);

   assign csr_ready  = 1'b1;
   assign rsp_valid  = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_value  = vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ibits_ff <= INDEX_BITS_RESET;
         clr_ff   <= '0;
         free_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         free_ff  <= free_in;
         rv_ff    <= rv_in;
         if (csr_valid) ibits_ff <= csr_data;
      end
      cmd_ff <= cmd_in; key_ff <= key_in; val_ff <= val_in; bkt_ff <= bkt_in;
      cur_ff <= cur_in; prev_ff <= prev_in; hop_ff <= hop_in;
      athead_ff <= athead_in; found_ff <= found_in; hvalid_ff <= hvalid_in;
      curnext_ff <= curnext_in; st_ff <= st_in; vo_ff <= vo_in;
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; free_in = free_ff; rv_in = rv_ff;
      cmd_in = cmd_ff; key_in = key_ff; val_in = val_ff; bkt_in = bkt_ff;
      cur_in = cur_ff; prev_in = prev_ff; hop_in = hop_ff;
      athead_in = athead_ff; found_in = found_ff; hvalid_in = hvalid_ff;
      curnext_in = curnext_ff; st_in = st_ff; vo_in = vo_ff;
      req_ready = 1'b0;
      b_raddr = bkt_ff; n_raddr = cur_ff[PW-1:0];
      b_waddr = bkt_ff; n_waddr = cur_ff[PW-1:0];
      bv_we = 1'b0; bkv_we = 1'b0; bn_we = 1'b0; nkv_we = 1'b0; nn_we = 1'b0;
      bv_wd = 1'b0; bn_wd = NIL; nn_wd = NIL; bval_wd = val_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // init bucket links/valid and the in-order free list
            b_waddr = clr_ff[BUCKET_BITS-1:0];
            n_waddr = clr_ff[PW-1:0];
            bv_we = (clr_ff < CW'(NB));
            bn_we = bv_we;
            nn_we = (clr_ff < CW'(POOL_NODES));
            nn_wd = LW'(clr_ff) + LW'(1);
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !rv_ff || rsp_ready;
            b_raddr = BUCKET_BITS'(req_key & bmask);
            if (req_valid && req_ready) begin
               cmd_in = cmd_type'(req_cmd); key_in = req_key; val_in = req_value;
               bkt_in = b_raddr;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            hvalid_in = bv_q;
            athead_in = bv_q && (bk_q == key_ff);
            found_in = 1'b0;
            prev_in = NIL; hop_in = '0;
            cur_in = bn_q;
            n_raddr = bn_q[PW-1:0];
            if (athead_in) begin
               cur_in = NIL;
               state_in = S_DECIDE;
            end else if (bn_q == NIL) state_in = S_DECIDE;
            else state_in = S_NODE;
         end
         S_NODE: begin
            // nk_q/nn_q hold node cur_ff
            if (nk_q == key_ff) begin
               found_in = 1'b1;
               curnext_in = nn_q;
               vo_in = nval_q;
               state_in = S_DECIDE;
            end else begin
               prev_in = cur_ff;
               cur_in = nn_q;
               n_raddr = nn_q[PW-1:0];
               hop_in = hop_ff + CW'(1);
               if (nn_q == NIL || hop_ff == CW'(POOL_NODES - 1)) begin
                  cur_in = NIL;
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            st_in = ST_NOT_FOUND; state_in = S_RESP;
            if (!found_ff) vo_in = bval_q;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  st_in = ST_DONE;
                  if (athead_ff) bkv_we = 1'b1;
                  else if (found_ff) nkv_we = 1'b1;
                  else if (!hvalid_ff) begin
                     bkv_we = 1'b1; bv_we = 1'b1; bv_wd = 1'b1;
                  end else if (free_ff == NIL) st_in = ST_POOL_FULL;
                  else begin
                     // claim free node: write it with a null next, fetch its old next
                     n_waddr = free_ff[PW-1:0]; nkv_we = 1'b1; nn_we = 1'b1;
                     nn_wd = NIL;
                     n_raddr = free_ff[PW-1:0];
                     cur_in = free_ff;
                     state_in = S_FREE;
                  end
               end
               CMD_LOOKUP: begin
                  if (athead_ff || found_ff) st_in = ST_DONE;
               end
               CMD_REMOVE: begin
                  if (athead_ff) begin
                     st_in = ST_DONE; bv_we = 1'b1; bv_wd = 1'b0;
                  end else if (found_ff) begin
                     st_in = ST_DONE;
                     if (prev_ff == NIL) begin
                        bn_we = 1'b1; bn_wd = curnext_ff;
                     end else begin
                        nn_we = 1'b1; n_waddr = prev_ff[PW-1:0]; nn_wd = curnext_ff;
                     end
                     state_in = S_FREE;
                  end
               end
               default: ;
            endcase
            if (!(cmd_ff == CMD_LOOKUP && (athead_ff || found_ff))) vo_in = '0;
         end
         S_FREE: begin
            state_in = S_RESP;
            if (cmd_ff == CMD_INSERT) begin
               // read of old free node returned before our write landed
               free_in = nn_q;
               if (prev_ff == NIL) begin
                  bn_we = 1'b1; bn_wd = cur_ff;
               end else begin
                  nn_we = 1'b1; n_waddr = prev_ff[PW-1:0]; nn_wd = cur_ff;
               end
            end else begin
               nn_we = 1'b1; n_waddr = cur_ff[PW-1:0]; nn_wd = free_ff;
               free_in = cur_ff;
            end
         end
         S_RESP: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/cht_checker.sv
// Checker: port-level properties of the hash table engine, bound to the top level.
`default_nettype none
module cht_checker
   import cht_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [1:0]             rsp_status,
   input wire [VALUE_WIDTH-1:0] rsp_value
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value))
      else $error("response changed while stalled");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != ST_RSVD)
      else $error("reserved status");
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_value == '0)
      else $error("value on failed command");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");
endmodule

bind chained_hash_table_engine cht_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_cht_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_value(rsp_value));
`default_nettype wire
